@@ hdl/mtd_pkg.sv @@
// morse text decoder: shared types, character and status codes, code lookup table
// used by the decoder, the result queue, the top level and the testbench; depends on nothing

package mtd_pkg;

    // item modes
    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADCHAR = 2'd1;
    localparam logic [1:0] ST_BADCODE = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NONE  = 8'h00;

    // longest code
    localparam logic [2:0] MAX_SYMBOLS = 3'd5;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    // one result transaction
    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] status;
        logic       last;
    } t_result;

    // results produced by one decoded item
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_wr;

    // code to character, zero for an empty or unknown code
    // symbol k sits in bit k, dash is one
    function automatic logic [7:0] lookup_code(input logic [2:0] len, input logic [4:0] sym);
        logic [7:0] c;
        begin
            c = CH_NONE;
            unique case (len)
                3'd1: c = sym[0] ? "t" : "e";
                3'd2: begin
                    unique case (sym[1:0])
                        2'd0: c = "i";
                        2'd1: c = "n";
                        2'd2: c = "a";
                        2'd3: c = "m";
                        default: c = CH_NONE;
                    endcase
                end
                3'd3: begin
                    unique case (sym[2:0])
                        3'd0: c = "s";
                        3'd1: c = "d";
                        3'd2: c = "r";
                        3'd3: c = "g";
                        3'd4: c = "u";
                        3'd5: c = "k";
                        3'd6: c = "w";
                        3'd7: c = "o";
                        default: c = CH_NONE;
                    endcase
                end
                3'd4: begin
                    unique case (sym[3:0])
                        4'd0:  c = "h";
                        4'd1:  c = "b";
                        4'd2:  c = "l";
                        4'd3:  c = "z";
                        4'd4:  c = "f";
                        4'd5:  c = "c";
                        4'd6:  c = "p";
                        4'd8:  c = "v";
                        4'd9:  c = "x";
                        4'd13: c = "y";
                        4'd14: c = "j";
                        default: c = CH_NONE;
                    endcase
                end
                3'd5: c = (sym == 5'd0) ? CH_DOT : CH_NONE;
                default: c = CH_NONE;
            endcase
            return c;
        end
    endfunction

endpackage

@@ hdl/mtd_in_if.sv @@
// morse text decoder: input channel, one Morse text character or end mark per transaction
// depends on nothing

interface mtd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] ch;

    modport source (output valid, output mode, output ch, input ready);
    modport sink (input valid, input mode, input ch, output ready);
endinterface

@@ hdl/mtd_out_if.sv @@
// morse text decoder: output channel, one decoded character or error per transaction
// depends on nothing

interface mtd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_char, output status, output last, input ready);
    modport sink (input valid, input out_char, input status, input last, output ready);
endinterface

@@ hdl/mtd_decode.sv @@
// morse text decoder: input register, decoder state and per-item decode logic
// depends on mtd_pkg and mtd_in_if

module mtd_decode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mtd_in_if.sink                    i_in,
    input  logic [mtd_pkg::CNT_W-1:0] i_fifo_count,
    output mtd_pkg::t_wr              o_wr
);

    // input register
    logic       r_valid;
    logic       r_mode;
    logic [7:0] r_ch;

    // decoder state
    logic [4:0] r_sym;
    logic [2:0] r_len;
    logic       r_skip;
    logic       r_bs;
    logic       r_halt;

    logic [4:0] n_sym;
    logic [2:0] n_len;
    logic       n_skip;
    logic       n_bs;
    logic       n_halt;

    logic [7:0]   w_code_char;
    logic [7:0]   w_ch;
    logic         w_fail;
    logic [1:0]   w_fail_st;
    logic [3:0]   w_fill;
    mtd_pkg::t_wr w_wr;

    // room for two more results once the item in the register has been written
    assign w_fill     = {1'b0, i_fifo_count} + {2'b00, w_wr.count};
    assign i_in.ready = (w_fill <= 4'(mtd_pkg::FIFO_DEPTH - 2));

    assign w_code_char = mtd_pkg::lookup_code(r_len, r_sym);

    // decode of the registered item
    always_comb begin
        n_sym     = r_sym;
        n_len     = r_len;
        n_skip    = r_skip;
        n_bs      = r_bs;
        n_halt    = r_halt;
        w_fail    = 1'b0;
        w_fail_st = mtd_pkg::ST_OK;
        w_ch      = r_ch;
        w_wr      = '0;
        if (r_valid && !r_halt) begin
            if (r_mode == mtd_pkg::MODE_END) begin
                if (r_bs) begin
                    w_fail    = 1'b1;
                    w_fail_st = mtd_pkg::ST_BADCHAR;
                end else if (r_len != 3'd0) begin
                    if (w_code_char == mtd_pkg::CH_NONE) begin
                        w_fail    = 1'b1;
                        w_fail_st = mtd_pkg::ST_BADCODE;
                    end else begin
                        w_wr.count = 2'd2;
                        w_wr.r0    = '{out_char: w_code_char, status: mtd_pkg::ST_OK, last: 1'b0};
                        w_wr.r1    = '{out_char: mtd_pkg::CH_NL, status: mtd_pkg::ST_OK, last: 1'b1};
                    end
                end else begin
                    w_wr.count = 2'd1;
                    w_wr.r0    = '{out_char: mtd_pkg::CH_NL, status: mtd_pkg::ST_OK, last: 1'b1};
                end
            end else if (r_bs && r_ch != mtd_pkg::CH_N) begin
                n_bs      = 1'b0;
                w_fail    = 1'b1;
                w_fail_st = mtd_pkg::ST_BADCHAR;
            end else begin
                // escaped n stands for a newline
                n_bs = 1'b0;
                if (r_bs) begin
                    w_ch = mtd_pkg::CH_NL;
                end
                priority if (w_ch == mtd_pkg::CH_DOT || w_ch == mtd_pkg::CH_DASH) begin
                    if (r_len >= mtd_pkg::MAX_SYMBOLS) begin
                        w_fail    = 1'b1;
                        w_fail_st = mtd_pkg::ST_BADCODE;
                    end else begin
                        n_sym[r_len] = (w_ch == mtd_pkg::CH_DASH);
                        n_len        = r_len + 3'd1;
                        n_skip       = 1'b0;
                    end
                end else if (w_ch == mtd_pkg::CH_BSL) begin
                    n_bs = 1'b1;
                end else if (w_ch == mtd_pkg::CH_SPACE) begin
                    if (r_len != 3'd0) begin
                        if (w_code_char == mtd_pkg::CH_NONE) begin
                            w_fail    = 1'b1;
                            w_fail_st = mtd_pkg::ST_BADCODE;
                        end else begin
                            n_sym      = '0;
                            n_len      = '0;
                            w_wr.count = 2'd1;
                            w_wr.r0    = '{out_char: w_code_char, status: mtd_pkg::ST_OK,
                                           last: 1'b1};
                        end
                    end else if (!r_skip) begin
                        n_skip     = 1'b1;
                        w_wr.count = 2'd1;
                        w_wr.r0    = '{out_char: mtd_pkg::CH_SPACE, status: mtd_pkg::ST_OK,
                                       last: 1'b1};
                    end
                end else if (w_ch == mtd_pkg::CH_NL) begin
                    if (w_code_char == mtd_pkg::CH_NONE) begin
                        w_fail    = 1'b1;
                        w_fail_st = mtd_pkg::ST_BADCODE;
                    end else begin
                        n_sym      = '0;
                        n_len      = '0;
                        n_skip     = 1'b0;
                        w_wr.count = 2'd2;
                        w_wr.r0    = '{out_char: w_code_char, status: mtd_pkg::ST_OK, last: 1'b0};
                        w_wr.r1    = '{out_char: mtd_pkg::CH_NL, status: mtd_pkg::ST_OK,
                                       last: 1'b1};
                    end
                end else begin
                    w_fail    = 1'b1;
                    w_fail_st = mtd_pkg::ST_BADCHAR;
                end
            end
        end
        // error: single result, code dropped, further items discarded
        if (w_fail) begin
            w_wr.count = 2'd1;
            w_wr.r0    = '{out_char: mtd_pkg::CH_NONE, status: w_fail_st, last: 1'b1};
            w_wr.r1    = '0;
            n_sym      = '0;
            n_len      = '0;
            n_skip     = 1'b0;
            n_bs       = 1'b0;
            n_halt     = 1'b1;
        end
        // end of message always leaves a clean state
        if (r_valid && r_mode == mtd_pkg::MODE_END) begin
            n_sym  = '0;
            n_len  = '0;
            n_skip = 1'b0;
            n_bs   = 1'b0;
            n_halt = 1'b0;
        end
    end

    assign o_wr = w_wr;

    // input register, emptied every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_in.valid && i_in.ready;
        end
        r_mode <= i_in.mode;
        r_ch   <= i_in.ch;
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym  <= '0;
            r_len  <= '0;
            r_skip <= 1'b0;
            r_bs   <= 1'b0;
            r_halt <= 1'b0;
        end else begin
            r_sym  <= n_sym;
            r_len  <= n_len;
            r_skip <= n_skip;
            r_bs   <= n_bs;
            r_halt <= n_halt;
        end
    end

endmodule

@@ hdl/mtd_out_fifo.sv @@
// morse text decoder: result queue taking up to two results a cycle, one out per transaction
// depends on mtd_pkg and mtd_out_if

module mtd_out_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mtd_pkg::t_wr              i_wr,
    mtd_out_if.source                 o_out,
    output logic [mtd_pkg::CNT_W-1:0] o_count
);

    localparam int PTR_W = mtd_pkg::PTR_W;
    localparam int CNT_W = mtd_pkg::CNT_W;

    mtd_pkg::t_result r_entry [mtd_pkg::FIFO_DEPTH];
    logic [mtd_pkg::PTR_W-1:0] r_wr_ptr;
    logic [mtd_pkg::PTR_W-1:0] r_rd_ptr;
    logic [mtd_pkg::CNT_W-1:0] r_count;

    logic [mtd_pkg::PTR_W-1:0] w_wr_ptr1;
    logic                      w_pop;

    assign w_wr_ptr1 = r_wr_ptr + PTR_W'(1);
    assign w_pop     = o_out.valid && o_out.ready;

    // head entry drives the output
    assign o_out.valid    = (r_count != '0);
    assign o_out.out_char = r_entry[r_rd_ptr].out_char;
    assign o_out.status   = r_entry[r_rd_ptr].status;
    assign o_out.last     = r_entry[r_rd_ptr].last;
    assign o_count        = r_count;

    // entry writes
    always_ff @(posedge i_clk) begin
        if (i_wr.count != 2'd0) begin
            r_entry[r_wr_ptr] <= i_wr.r0;
        end
        if (i_wr.count == 2'd2) begin
            r_entry[w_wr_ptr1] <= i_wr.r1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_wr.count);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_wr.count) - CNT_W'(w_pop);
        end
    end

endmodule

@@ hdl/morse_text_decoder_top.sv @@
// morse text decoder top level: input register and decoder feeding a small result queue
// depends on mtd_pkg, mtd_in_if, mtd_out_if, mtd_decode and mtd_out_fifo
//
// Usage
//  i_in carries one transaction per Morse text character (mode 0, ch) or an end of
//  message mark (mode 1). o_out returns decoded characters, one per transaction, with
//  status and a last flag on the final result of each item. An item gives zero, one
//  or two results; an error gives one result with out_char zero and status set, after
//  which items are dropped until the end mark.
//  An accepted item is held in the input register and decoded from there; its results
//  are written into the result queue, from which the receiver takes them.
//  Throughput: one item per cycle while the receiver takes results and items give at most
//  one result each; items that give two results are bound by the output, one result per
//  cycle. The bound comes from the four-entry result queue: i_in.ready is high while the
//  queue, counting the item held in the input register, keeps room for two more results.
//  When the receiver stalls the queue fills and i_in.ready drops; nothing is lost.
//  Reset (i_rst_n low, synchronous) clears the code, flags and queue; the block takes
//  items from the first cycle after reset.

module morse_text_decoder_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtd_in_if.sink    i_in,
    mtd_out_if.source o_out
);

    localparam int CNT_W = mtd_pkg::CNT_W;

    mtd_pkg::t_wr              w_wr;
    logic [mtd_pkg::CNT_W-1:0] w_count;

    // decode stage
    mtd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_fifo_count (w_count),
        .o_wr         (w_wr)
    );

    // result queue
    mtd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_out   (o_out),
        .o_count (w_count)
    );

    // queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(mtd_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    // a pair of results carries last only on the second
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.count == 2'd2 |-> !w_wr.r0.last && w_wr.r1.last)
        else $error("last flag misplaced in result pair");

    // an error result is zero and ends its item
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != mtd_pkg::ST_OK |-> o_out.out_char == 8'h00 && o_out.last)
        else $error("malformed error result");

    // queue empty in the cycle after reset is seen
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("results visible after reset");

endmodule

@@ sim/morse_text_decoder_top_test.sv @@
// testbench for morse_text_decoder_top: directed and random Morse text, checked against
// a decoder model kept in step with every accepted transaction
// depends on mtd_pkg, mtd_in_if, mtd_out_if and morse_text_decoder_top

module morse_text_decoder_top_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 620;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #4 i_clk = ~i_clk;

    mtd_in_if  in_bus ();
    mtd_out_if out_bus ();

    morse_text_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // decoder state as the model sees it
    logic [4:0] code_sym;
    logic [2:0] code_len;
    logic       skip_spaces;
    logic       bsl_seen;
    logic       halted;

    mtd_pkg::t_result decoded_q[$];

    int  errors     = 0;
    int  cycles     = 0;
    int  live_items = 0;
    int  stall_left = 0;
    bit  in_idle_on;
    bit  out_idle_on;

    // code to character, zero for an empty or unknown code
    function automatic logic [7:0] morse_char(input logic [2:0] len, input logic [4:0] sym);
        string      pat;
        logic [7:0] c;
        int         k;
        pat = "";
        for (k = 0; k < len; k++) begin
            if (sym[k]) pat = {pat, "-"};
            else pat = {pat, "."};
        end
        case (pat)
            ".":     c = "e";
            "-":     c = "t";
            "..":    c = "i";
            "-.":    c = "n";
            ".-":    c = "a";
            "--":    c = "m";
            "...":   c = "s";
            "-..":   c = "d";
            ".-.":   c = "r";
            "--.":   c = "g";
            "..-":   c = "u";
            "-.-":   c = "k";
            ".--":   c = "w";
            "---":   c = "o";
            "....":  c = "h";
            "-...":  c = "b";
            ".-..":  c = "l";
            "--..":  c = "z";
            "..-.":  c = "f";
            "-.-.":  c = "c";
            ".--.":  c = "p";
            "...-":  c = "v";
            "-..-":  c = "x";
            "-.--":  c = "y";
            ".---":  c = "j";
            ".....": c = mtd_pkg::CH_DOT;
            default: c = mtd_pkg::CH_NONE;
        endcase
        return c;
    endfunction

    function automatic void clear_decoder();
        code_sym    = '0;
        code_len    = '0;
        skip_spaces = 1'b0;
        bsl_seen    = 1'b0;
        halted      = 1'b0;
    endfunction

    function automatic void expect_char(input logic [7:0] c, input logic is_last);
        decoded_q.push_back(mtd_pkg::t_result'{out_char: c, status: mtd_pkg::ST_OK,
                                               last: is_last});
    endfunction

    // an error result ends the message until the end mark
    function automatic void expect_error(input logic [1:0] st);
        decoded_q.push_back(mtd_pkg::t_result'{out_char: mtd_pkg::CH_NONE, status: st,
                                               last: 1'b1});
        clear_decoder();
        halted = 1'b1;
    endfunction

    // advance the decoder model by one accepted transaction
    function automatic void predict_item(input logic mode, input logic [7:0] ch);
        logic [7:0] c;
        logic [7:0] sym_ch;
        sym_ch = ch;
        if (mode == mtd_pkg::MODE_END) begin
            if (!halted) begin
                c = morse_char(code_len, code_sym);
                if (bsl_seen) begin
                    expect_error(mtd_pkg::ST_BADCHAR);
                end else if (code_len != 0 && c == mtd_pkg::CH_NONE) begin
                    expect_error(mtd_pkg::ST_BADCODE);
                end else begin
                    if (code_len != 0) expect_char(c, 1'b0);
                    expect_char(mtd_pkg::CH_NL, 1'b1);
                end
            end
            clear_decoder();
            return;
        end
        if (halted) return;
        // escaped newline
        if (bsl_seen) begin
            bsl_seen = 1'b0;
            if (sym_ch != mtd_pkg::CH_N) begin
                expect_error(mtd_pkg::ST_BADCHAR);
                return;
            end
            sym_ch = mtd_pkg::CH_NL;
        end
        case (sym_ch)
            mtd_pkg::CH_DOT, mtd_pkg::CH_DASH: begin
                if (code_len >= mtd_pkg::MAX_SYMBOLS) begin
                    expect_error(mtd_pkg::ST_BADCODE);
                end else begin
                    code_sym[code_len] = (sym_ch == mtd_pkg::CH_DASH);
                    code_len           = code_len + 3'd1;
                    skip_spaces        = 1'b0;
                end
            end
            mtd_pkg::CH_BSL: bsl_seen = 1'b1;
            mtd_pkg::CH_SPACE: begin
                if (code_len != 0) begin
                    c = morse_char(code_len, code_sym);
                    if (c == mtd_pkg::CH_NONE) begin
                        expect_error(mtd_pkg::ST_BADCODE);
                    end else begin
                        code_sym = '0;
                        code_len = '0;
                        expect_char(c, 1'b1);
                    end
                end else if (!skip_spaces) begin
                    skip_spaces = 1'b1;
                    expect_char(mtd_pkg::CH_SPACE, 1'b1);
                end
            end
            mtd_pkg::CH_NL: begin
                c = morse_char(code_len, code_sym);
                if (c == mtd_pkg::CH_NONE) begin
                    expect_error(mtd_pkg::ST_BADCODE);
                end else begin
                    code_sym    = '0;
                    code_len    = '0;
                    skip_spaces = 1'b0;
                    expect_char(c, 1'b0);
                    expect_char(mtd_pkg::CH_NL, 1'b1);
                end
            end
            default: expect_error(mtd_pkg::ST_BADCHAR);
        endcase
    endfunction

    // send one transaction, with an occasional idle burst in front
    task automatic send_item(input logic mode, input logic [7:0] ch);
        if (in_idle_on && $urandom_range(0, 5) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.mode  <= mode;
        in_bus.ch    <= ch;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        if (!halted || mode == mtd_pkg::MODE_END) live_items++;
        predict_item(mode, ch);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_item(mtd_pkg::MODE_CHAR, s[i]);
    endtask

    // symbol k of the code is bit k, dash is one
    task automatic send_code(input int len, input logic [5:0] sym);
        int k;
        for (k = 0; k < len; k++) begin
            send_item(mtd_pkg::MODE_CHAR, sym[k] ? mtd_pkg::CH_DASH : mtd_pkg::CH_DOT);
        end
    endtask

    task automatic send_letter();
        logic [2:0] len;
        logic [4:0] sym;
        do begin
            len = 3'($urandom_range(1, 5));
            sym = 5'($urandom);
        end while (morse_char(len, sym) == mtd_pkg::CH_NONE);
        send_code(len, {1'b0, sym});
    endtask

    task automatic send_newline();
        if ($urandom_range(0, 1)) begin
            send_item(mtd_pkg::MODE_CHAR, mtd_pkg::CH_NL);
        end else begin
            send_item(mtd_pkg::MODE_CHAR, mtd_pkg::CH_BSL);
            send_item(mtd_pkg::MODE_CHAR, mtd_pkg::CH_N);
        end
    endtask

    // hold the sender off until every expected result has been taken
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_text(".-  ");          // letter ended by a space, then a word space
        send_text(".....\n");       // five dots give a full stop, then newline
        send_text("-\\n");          // escaped newline
        send_item(mtd_pkg::MODE_END, 8'hFF); // end mark with nothing pending
        send_text("\n.");           // newline on an empty code, then a dropped dot
        send_item(mtd_pkg::MODE_END, mtd_pkg::CH_NONE);
        send_text("\\");            // backslash followed by something other than n
        send_item(mtd_pkg::MODE_CHAR, mtd_pkg::CH_NONE);
        send_item(mtd_pkg::MODE_END, mtd_pkg::CH_NONE);
        send_text("------");        // sixth symbol
        send_item(mtd_pkg::MODE_END, mtd_pkg::CH_NONE);
        send_text("--.-");          // no q in the table, unknown code at end mark
        send_item(mtd_pkg::MODE_END, mtd_pkg::CH_NONE);
        send_text("\\");            // backslash left pending at end mark
        send_item(mtd_pkg::MODE_END, 8'h5A);
        send_item(mtd_pkg::MODE_CHAR, 8'hFF); // invalid character
        send_item(mtd_pkg::MODE_END, mtd_pkg::CH_NONE);
        wait_drained();
    endtask

    // mostly well-formed text, with malformed codes and noise mixed in
    task automatic test_random_traffic(input int n_items);
        int goal;
        int pick;
        goal = live_items + n_items;
        while (live_items < goal) begin
            pick = $urandom_range(0, 99);
            if (halted && $urandom_range(0, 3) != 0) begin
                send_item(mtd_pkg::MODE_END, 8'($urandom));
            end else if (pick < 55) begin
                send_letter();
                send_item(mtd_pkg::MODE_CHAR, mtd_pkg::CH_SPACE);
            end else if (pick < 65) begin
                send_item(mtd_pkg::MODE_CHAR, mtd_pkg::CH_SPACE);
            end else if (pick < 72) begin
                send_letter();
                send_newline();
            end else if (pick < 80) begin
                if ($urandom_range(0, 1)) send_letter();
                send_item(mtd_pkg::MODE_END, 8'($urandom));
            end else if (pick < 86) begin
                // arbitrary run of symbols, possibly unknown or over-long
                send_code($urandom_range(1, 6), 6'($urandom));
                if ($urandom_range(0, 1)) send_item(mtd_pkg::MODE_CHAR, mtd_pkg::CH_SPACE);
                else send_newline();
            end else if (pick < 91) begin
                send_item(mtd_pkg::MODE_CHAR, mtd_pkg::CH_BSL);
                send_item(mtd_pkg::MODE_CHAR,
                          $urandom_range(0, 1) ? mtd_pkg::CH_N : 8'($urandom));
            end else if (pick < 96) begin
                send_item(mtd_pkg::MODE_CHAR, 8'($urandom));
            end else begin
                send_item(mtd_pkg::MODE_END, 8'($urandom));
            end
        end
    endtask

    task automatic test_sender_pause();
        repeat (4) begin
            send_letter();
            send_item(mtd_pkg::MODE_CHAR, mtd_pkg::CH_SPACE);
            send_letter();
            send_newline();
            wait_drained();
        end
    endtask

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            out_bus.ready <= 1'b0;
        end else if (out_idle_on && $urandom_range(0, 6) == 0) begin
            stall_left    <= $urandom_range(0, 9);
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        mtd_pkg::t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual char %0h status %0d last %0b",
                         $time, out_bus.out_char, out_bus.status, out_bus.last);
                errors++;
            end else begin
                want = decoded_q.pop_front();
                check_field("out_char", want.out_char, out_bus.out_char);
                check_field("status", 8'(want.status), 8'(out_bus.status));
                check_field("last", 8'(want.last), 8'(out_bus.last));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("morse_text_decoder_top_test: done, errors");
            $finish;
        end
    end

    initial begin
        in_bus.valid  <= 1'b0;
        in_bus.mode   <= mtd_pkg::MODE_CHAR;
        in_bus.ch     <= mtd_pkg::CH_NONE;
        i_rst_n       <= 1'b0;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        clear_decoder();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        test_random_traffic(RANDOM_ITEMS * 3 / 4);
        test_sender_pause();
        // closing stretch at full rate on both sides
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        test_random_traffic(RANDOM_ITEMS / 4);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("morse_text_decoder_top_test: done, clean");
        end else begin
            $display("morse_text_decoder_top_test: done, errors");
        end
        $finish;
    end

endmodule
